@@ rtl/core/source_comment_stripper_top_assert.svh @@
// Assertion macros for the source comment stripper.
// Each macro takes a label and checks on the rising edge of clk_i while out of reset.
`ifndef SOURCE_COMMENT_STRIPPER_TOP_ASSERT_SVH
`define SOURCE_COMMENT_STRIPPER_TOP_ASSERT_SVH

// The condition holds at every clock edge.
`define SCS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("scs check failed");

// When the antecedent holds, the consequent holds at the same edge.
`define SCS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scs check failed");

// When the antecedent holds, the consequent holds at the next edge.
`define SCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scs check failed");

`endif

@@ rtl/core/scs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package scs_pkg;

  // Language modes held in the configuration register.
  localparam logic [1:0] MODE_COPY = 2'd0;
  localparam logic [1:0] MODE_ASM  = 2'd1;
  localparam logic [1:0] MODE_C    = 2'd2;

  // Register index, taken from paddr bit 2.
  localparam logic REG_IDX_MODE = 1'b0;

  // Characters that the actions insert.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [3:0] ASM_STATES = 4'd14;
  localparam logic [3:0] C_STATES   = 4'd13;

  // Token classes shared by both languages.
  localparam logic [3:0] CLS_NL    = 4'd0;
  localparam logic [3:0] CLS_SPACE = 4'd1;
  localparam logic [3:0] CLS_TAB   = 4'd2;

  // Assembler token classes.
  localparam logic [3:0] CLS_A_SEMI  = 4'd3;
  localparam logic [3:0] CLS_A_STAR  = 4'd4;
  localparam logic [3:0] CLS_A_COLON = 4'd5;
  localparam logic [3:0] CLS_A_DQ    = 4'd6;
  localparam logic [3:0] CLS_A_SQ    = 4'd7;
  localparam logic [3:0] CLS_A_COMMA = 4'd8;
  localparam logic [3:0] CLS_A_LT    = 4'd9;
  localparam logic [3:0] CLS_A_GT    = 4'd10;
  localparam logic [3:0] CLS_A_OTHER = 4'd11;

  // C token classes.
  localparam logic [3:0] CLS_C_SLASH = 4'd3;
  localparam logic [3:0] CLS_C_STAR  = 4'd4;
  localparam logic [3:0] CLS_C_DQ    = 4'd5;
  localparam logic [3:0] CLS_C_SQ    = 4'd6;
  localparam logic [3:0] CLS_C_BSL   = 4'd7;
  localparam logic [3:0] CLS_C_OTHER = 4'd8;

  typedef enum logic [2:0] {
    ACT_ERROR     = 3'd0,
    ACT_DROP      = 3'd1,
    ACT_COPY      = 3'd2,
    ACT_NL        = 3'd3,
    ACT_TABCOPY   = 3'd4,
    ACT_SLASH     = 3'd5,
    ACT_SLASHCOPY = 3'd6,
    ACT_NLCOPY    = 3'd7
  } act_e;

  // One result transaction.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } scs_res_t;

  // Everything one input byte produces: a count and up to two results.
  typedef struct packed {
    logic [1:0] n;
    scs_res_t   r0;
    scs_res_t   r1;
  } scs_dec_t;

  localparam logic [3:0] ASM_NEXT [14][12] = '{
    '{0,2,2,1,1,0,0,0,0,0,0,3},
    '{0,1,1,1,1,1,1,1,1,1,1,1},
    '{0,2,2,1,2,2,2,2,2,2,2,5},
    '{0,4,4,1,3,4,3,3,3,3,3,3},
    '{0,4,4,1,5,4,4,4,4,4,4,5},
    '{0,6,6,1,5,4,5,5,5,5,5,5},
    '{0,6,6,1,8,6,9,11,7,13,6,8},
    '{0,1,1,1,8,7,9,11,7,13,7,8},
    '{0,1,1,1,8,8,9,11,7,8,8,8},
    '{9,9,9,9,9,9,10,9,9,9,9,9},
    '{0,1,1,1,10,10,9,10,7,8,8,8},
    '{11,11,11,11,11,11,11,12,11,11,11,11},
    '{0,1,1,1,12,12,12,11,7,8,8,8},
    '{13,13,13,13,13,13,13,13,13,13,8,13}
  };

  localparam logic [2:0] ASM_ACT [14][12] = '{
    '{1,1,1,1,1,0,0,0,0,0,0,2},
    '{1,1,1,1,1,1,1,1,1,1,1,1},
    '{1,1,1,1,0,0,0,0,0,0,0,4},
    '{2,1,1,3,2,1,0,0,0,0,0,2},
    '{2,1,1,3,4,0,0,0,0,0,0,4},
    '{2,1,1,3,2,1,0,0,0,0,0,2},
    '{2,1,1,3,4,0,4,4,4,4,0,4},
    '{2,3,3,3,2,0,2,2,2,2,0,2},
    '{2,3,3,3,2,0,2,2,2,2,2,2},
    '{0,2,2,2,2,2,2,2,2,2,2,2},
    '{2,3,3,3,0,0,2,0,2,2,2,2},
    '{0,2,2,2,2,2,2,2,2,2,2,2},
    '{2,3,3,3,0,0,0,2,2,2,2,2},
    '{0,2,2,2,2,2,2,2,2,2,2,2}
  };

  localparam logic [3:0] C_NEXT [13][9] = '{
    '{0,0,0,1,4,9,11,4,4},
    '{0,5,5,6,2,9,11,4,4},
    '{2,2,2,2,3,2,2,2,2},
    '{2,2,2,0,3,2,2,2,2},
    '{0,5,5,6,4,9,11,4,4},
    '{0,5,5,6,4,9,11,4,4},
    '{0,5,5,6,7,9,11,4,4},
    '{2,7,7,7,8,7,7,7,7},
    '{2,7,7,5,8,7,7,7,7},
    '{9,9,9,9,9,4,9,10,9},
    '{10,9,9,9,9,9,9,9,9},
    '{11,11,11,11,11,11,4,12,11},
    '{12,11,11,11,11,11,11,11,11}
  };

  localparam logic [2:0] C_ACT [13][9] = '{
    '{1,1,1,1,2,2,2,2,2},
    '{6,5,5,5,1,6,6,6,6},
    '{1,1,1,1,1,1,1,1,1},
    '{1,1,1,1,1,1,1,1,1},
    '{2,1,1,1,2,2,2,2,2},
    '{2,1,1,1,4,4,4,4,4},
    '{6,5,5,5,1,6,6,6,6},
    '{2,1,1,1,1,1,1,1,1},
    '{2,1,1,1,1,1,1,1,1},
    '{0,2,2,2,2,2,2,2,2},
    '{0,2,2,2,2,2,2,2,2},
    '{0,2,2,2,2,2,2,2,2},
    '{0,2,2,2,2,2,2,2,2}
  };

  function automatic logic [3:0] asm_class(input logic [7:0] b);
    case (b)
      CH_NL:    return CLS_NL;
      CH_SPACE: return CLS_SPACE;
      CH_TAB:   return CLS_TAB;
      8'h3B:    return CLS_A_SEMI;
      8'h2A:    return CLS_A_STAR;
      8'h3A:    return CLS_A_COLON;
      8'h22:    return CLS_A_DQ;
      8'h27:    return CLS_A_SQ;
      8'h2C:    return CLS_A_COMMA;
      8'h3C:    return CLS_A_LT;
      8'h3E:    return CLS_A_GT;
      default:  return CLS_A_OTHER;
    endcase
  endfunction

  function automatic logic [3:0] c_class(input logic [7:0] b);
    case (b)
      CH_NL:    return CLS_NL;
      CH_SPACE: return CLS_SPACE;
      CH_TAB:   return CLS_TAB;
      CH_SLASH: return CLS_C_SLASH;
      8'h2A:    return CLS_C_STAR;
      8'h22:    return CLS_C_DQ;
      8'h27:    return CLS_C_SQ;
      8'h5C:    return CLS_C_BSL;
      default:  return CLS_C_OTHER;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/source_comment_stripper_top.sv @@
// Source comment stripper: a byte-serial text filter.
// Input channel: in_valid_i / in_stall_o carry one source byte per transaction.
// Output channel: out_valid_o / out_stall_i carry one result byte per
// transaction, with last_of_run_o marking the final result of an input byte
// and error_flag_o marking a table error (the block then drops all later input
// until reset).
// Configuration: an APB-style port with one register, language_mode, at byte
// address 0 (0 copy, 1 assembler, 2 C, 3 copy). Writing it restarts the scan in
// the newline state; write it only while no transaction is in flight.
// An accepted byte waits in the input register until all of its results fit
// in the two-entry result buffer, into which it is then decoded; the buffer's
// head slot offers the first result. Throughput: one input byte per cycle
// when it yields zero or one result and the receiver does not stall; a byte
// with two results waits until the single-byte output port empties the buffer.
// Reset clears the mode to copy, the scan state, the halt flag and both queues.
// When the receiver stalls, the result buffer fills, and the input register
// then holds its byte and raises in_stall_o until space opens again.
`timescale 1ns / 1ps
`default_nettype none

module source_comment_stripper_top import scs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o,
  output logic             error_flag_o
);

  // Configuration port: single register, always ready.
  logic       cfg_we;
  logic [1:0] mode;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_IDX_MODE);
  assign prdata = (paddr[2] == REG_IDX_MODE) ? {30'd0, mode} : 32'd0;

  // Input register: one byte waiting to be decoded.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_accept;
  logic       load;

  assign in_stall_o = in_vld_q && !load;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (load) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= in_byte_i;
    end
  end

  // Decoder and scan state. The state only moves when the byte is loaded or the mode is written.
  scs_dec_t dec;

  scs_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_mode_i  (pwdata[1:0]),
    .item_byte_i (in_byte_q),
    .item_take_i (load),
    .dec_o       (dec),
    .mode_o      (mode)
  );

  // Result buffer: two entries, slot 0 is the head. A byte is loaded only if
  // all of its results fit after this cycle's pop, so nothing is ever split.
  scs_res_t   slot_q [2];
  scs_res_t   slot_d [2];
  logic [1:0] cnt_q, cnt_d, cnt_pop;
  logic [2:0] fill;
  logic       pop;

  assign pop     = (cnt_q != 2'd0) && !out_stall_i;
  assign cnt_pop = cnt_q - {1'b0, pop};
  assign fill    = {1'b0, cnt_pop} + {1'b0, dec.n};
  assign load    = in_vld_q && (fill <= 3'd2);

  always_comb begin
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    cnt_d     = cnt_pop;
    if (pop) begin
      slot_d[0] = slot_q[1];
    end
    if (load) begin
      case (dec.n)
        2'd1: begin
          slot_d[cnt_pop[0]] = dec.r0;
        end
        2'd2: begin
          slot_d[0] = dec.r0;
          slot_d[1] = dec.r1;
        end
        default: begin
        end
      endcase
      cnt_d = fill[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

  assign out_valid_o   = (cnt_q != 2'd0);
  assign out_byte_o    = slot_q[0].data;
  assign last_of_run_o = slot_q[0].last;
  assign error_flag_o  = slot_q[0].err;

  `include "source_comment_stripper_top_assert.svh"

  // The buffer never holds more than two results.
  `SCS_ASSERT_ALWAYS(a_cnt_range, cnt_q <= 2'd2)
  // A byte with two results only loads when the buffer is empty after this cycle's pop.
  `SCS_ASSERT_SAME(a_pair_fits, load && (dec.n == 2'd2), cnt_pop == 2'd0)
  // An error result always closes its run.
  `SCS_ASSERT_SAME(a_err_last, out_valid_o && error_flag_o, last_of_run_o)
  // Nothing follows an error result once it has been taken.
  `SCS_ASSERT_NEXT(a_err_final, out_valid_o && error_flag_o && !out_stall_i, !out_valid_o)
  // A byte held in the input register keeps its value until loaded.
  `SCS_ASSERT_NEXT(a_in_hold, in_vld_q && !load, in_vld_q && $stable(in_byte_q))

endmodule

`default_nettype wire

@@ rtl/core/scs_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Holds the scan state, the halt flag and the language mode, and decodes one
// byte into its results. State advances only when the caller takes the item.
module scs_scan import scs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_mode_i,
  input  wire logic [7:0] item_byte_i,
  input  wire logic       item_take_i,
  output scs_dec_t        dec_o,
  output logic [1:0]      mode_o
);

  logic [1:0] mode_q, mode_d;
  logic [3:0] scan_q, scan_d;
  logic       halted_q, halted_d;

  logic [3:0] st_asm, st_c, cls_asm, cls_c, nxt;
  logic       table_mode;
  act_e       act;

  always_comb begin
    st_asm  = (scan_q >= ASM_STATES) ? 4'd0 : scan_q;
    st_c    = (scan_q >= C_STATES) ? 4'd0 : scan_q;
    cls_asm = asm_class(item_byte_i);
    cls_c   = c_class(item_byte_i);
    if (mode_q == MODE_ASM) begin
      act = act_e'(ASM_ACT[st_asm][cls_asm]);
      nxt = ASM_NEXT[st_asm][cls_asm];
    end else begin
      act = act_e'(C_ACT[st_c][cls_c]);
      nxt = C_NEXT[st_c][cls_c];
    end
    table_mode = (mode_q == MODE_ASM) || (mode_q == MODE_C);
  end

  always_comb begin
    dec_o = '0;
    if (halted_q) begin
      dec_o.n = 2'd0;
    end else if (!table_mode) begin
      dec_o.n  = 2'd1;
      dec_o.r0 = '{data: item_byte_i, last: 1'b1, err: 1'b0};
    end else begin
      case (act)
        ACT_ERROR: begin
          dec_o.n  = 2'd1;
          dec_o.r0 = '{data: 8'h00, last: 1'b1, err: 1'b1};
        end
        ACT_DROP: begin
          dec_o.n = 2'd0;
        end
        ACT_COPY: begin
          dec_o.n  = 2'd1;
          dec_o.r0 = '{data: item_byte_i, last: 1'b1, err: 1'b0};
        end
        ACT_NL: begin
          dec_o.n  = 2'd1;
          dec_o.r0 = '{data: CH_NL, last: 1'b1, err: 1'b0};
        end
        ACT_TABCOPY: begin
          dec_o.n  = 2'd2;
          dec_o.r0 = '{data: CH_TAB, last: 1'b0, err: 1'b0};
          dec_o.r1 = '{data: item_byte_i, last: 1'b1, err: 1'b0};
        end
        ACT_SLASH: begin
          dec_o.n  = 2'd1;
          dec_o.r0 = '{data: CH_SLASH, last: 1'b1, err: 1'b0};
        end
        ACT_SLASHCOPY: begin
          dec_o.n  = 2'd2;
          dec_o.r0 = '{data: CH_SLASH, last: 1'b0, err: 1'b0};
          dec_o.r1 = '{data: item_byte_i, last: 1'b1, err: 1'b0};
        end
        ACT_NLCOPY: begin
          dec_o.n  = 2'd2;
          dec_o.r0 = '{data: CH_NL, last: 1'b0, err: 1'b0};
          dec_o.r1 = '{data: item_byte_i, last: 1'b1, err: 1'b0};
        end
        default: begin
          dec_o.n = 2'd0;
        end
      endcase
    end
  end

  always_comb begin
    mode_d   = mode_q;
    scan_d   = scan_q;
    halted_d = halted_q;
    if (cfg_we_i) begin
      mode_d = cfg_mode_i;
      scan_d = 4'd0;
    end else if (item_take_i && !halted_q && table_mode) begin
      scan_d = nxt;
      if (act == ACT_ERROR) begin
        halted_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_COPY;
      scan_q   <= 4'd0;
      halted_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      scan_q   <= scan_d;
      halted_q <= halted_d;
    end
  end

  assign mode_o = mode_q;

endmodule

`default_nettype wire

@@ bench/source_comment_stripper_top_tb.sv @@
`timescale 1ns / 1ps

module source_comment_stripper_top_tb;
  import scs_pkg::*;

  // The spare mode code; the block treats it as plain copy.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  // The language mode register sits at byte address zero.
  localparam logic [2:0] MODE_ADDR = {REG_IDX_MODE, 2'b00};

  // Short names for the actions keep the scan tables readable.
  localparam act_e ER = ACT_ERROR;
  localparam act_e DR = ACT_DROP;
  localparam act_e CP = ACT_COPY;
  localparam act_e NL = ACT_NL;
  localparam act_e TC = ACT_TABCOPY;
  localparam act_e SL = ACT_SLASH;
  localparam act_e SC = ACT_SLASHCOPY;

  localparam int ASM_ROWS  = 14;
  localparam int CSRC_ROWS = 13;

  // Token sets in class order. A byte outside a set falls into the class
  // just past its end.
  localparam logic [7:0] ASM_TOKENS [11] = '{
    8'h0A, 8'h20, 8'h09, 8'h3B, 8'h2A, 8'h3A, 8'h22, 8'h27, 8'h2C, 8'h3C, 8'h3E
  };
  localparam logic [7:0] CSRC_TOKENS [8] = '{
    8'h0A, 8'h20, 8'h09, 8'h2F, 8'h2A, 8'h22, 8'h27, 8'h5C
  };

  // Assembler scan: next state and action per state row and token column.
  localparam logic [3:0] ASM_GOTO [14][12] = '{
    '{0, 2, 2, 1, 1, 0, 0, 0, 0, 0, 0, 3},
    '{0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1},
    '{0, 2, 2, 1, 2, 2, 2, 2, 2, 2, 2, 5},
    '{0, 4, 4, 1, 3, 4, 3, 3, 3, 3, 3, 3},
    '{0, 4, 4, 1, 5, 4, 4, 4, 4, 4, 4, 5},
    '{0, 6, 6, 1, 5, 4, 5, 5, 5, 5, 5, 5},
    '{0, 6, 6, 1, 8, 6, 9, 11, 7, 13, 6, 8},
    '{0, 1, 1, 1, 8, 7, 9, 11, 7, 13, 7, 8},
    '{0, 1, 1, 1, 8, 8, 9, 11, 7, 8, 8, 8},
    '{9, 9, 9, 9, 9, 9, 10, 9, 9, 9, 9, 9},
    '{0, 1, 1, 1, 10, 10, 9, 10, 7, 8, 8, 8},
    '{11, 11, 11, 11, 11, 11, 11, 12, 11, 11, 11, 11},
    '{0, 1, 1, 1, 12, 12, 12, 11, 7, 8, 8, 8},
    '{13, 13, 13, 13, 13, 13, 13, 13, 13, 13, 8, 13}
  };
  localparam act_e ASM_DO [14][12] = '{
    '{DR, DR, DR, DR, DR, ER, ER, ER, ER, ER, ER, CP},
    '{DR, DR, DR, DR, DR, DR, DR, DR, DR, DR, DR, DR},
    '{DR, DR, DR, DR, ER, ER, ER, ER, ER, ER, ER, TC},
    '{CP, DR, DR, NL, CP, DR, ER, ER, ER, ER, ER, CP},
    '{CP, DR, DR, NL, TC, ER, ER, ER, ER, ER, ER, TC},
    '{CP, DR, DR, NL, CP, DR, ER, ER, ER, ER, ER, CP},
    '{CP, DR, DR, NL, TC, ER, TC, TC, TC, TC, ER, TC},
    '{CP, NL, NL, NL, CP, ER, CP, CP, CP, CP, ER, CP},
    '{CP, NL, NL, NL, CP, ER, CP, CP, CP, CP, CP, CP},
    '{ER, CP, CP, CP, CP, CP, CP, CP, CP, CP, CP, CP},
    '{CP, NL, NL, NL, ER, ER, CP, ER, CP, CP, CP, CP},
    '{ER, CP, CP, CP, CP, CP, CP, CP, CP, CP, CP, CP},
    '{CP, NL, NL, NL, ER, ER, ER, CP, CP, CP, CP, CP},
    '{ER, CP, CP, CP, CP, CP, CP, CP, CP, CP, CP, CP}
  };

  // C scan: the same layout over nine token columns.
  localparam logic [3:0] CSRC_GOTO [13][9] = '{
    '{0, 0, 0, 1, 4, 9, 11, 4, 4},
    '{0, 5, 5, 6, 2, 9, 11, 4, 4},
    '{2, 2, 2, 2, 3, 2, 2, 2, 2},
    '{2, 2, 2, 0, 3, 2, 2, 2, 2},
    '{0, 5, 5, 6, 4, 9, 11, 4, 4},
    '{0, 5, 5, 6, 4, 9, 11, 4, 4},
    '{0, 5, 5, 6, 7, 9, 11, 4, 4},
    '{2, 7, 7, 7, 8, 7, 7, 7, 7},
    '{2, 7, 7, 5, 8, 7, 7, 7, 7},
    '{9, 9, 9, 9, 9, 4, 9, 10, 9},
    '{10, 9, 9, 9, 9, 9, 9, 9, 9},
    '{11, 11, 11, 11, 11, 11, 4, 12, 11},
    '{12, 11, 11, 11, 11, 11, 11, 11, 11}
  };
  localparam act_e CSRC_DO [13][9] = '{
    '{DR, DR, DR, DR, CP, CP, CP, CP, CP},
    '{SC, SL, SL, SL, DR, SC, SC, SC, SC},
    '{DR, DR, DR, DR, DR, DR, DR, DR, DR},
    '{DR, DR, DR, DR, DR, DR, DR, DR, DR},
    '{CP, DR, DR, DR, CP, CP, CP, CP, CP},
    '{CP, DR, DR, DR, TC, TC, TC, TC, TC},
    '{SC, SL, SL, SL, DR, SC, SC, SC, SC},
    '{CP, DR, DR, DR, DR, DR, DR, DR, DR},
    '{CP, DR, DR, DR, DR, DR, DR, DR, DR},
    '{ER, CP, CP, CP, CP, CP, CP, CP, CP},
    '{ER, CP, CP, CP, CP, CP, CP, CP, CP},
    '{ER, CP, CP, CP, CP, CP, CP, CP, CP},
    '{ER, CP, CP, CP, CP, CP, CP, CP, CP}
  };

  // Random phases: the language mode of each one, the plain copy extremes
  // included, and the number of source bytes per phase.
  localparam int PHASES = 11;
  localparam int PHASE_BYTES = 150;
  localparam logic [1:0] PHASE_MODES [PHASES] = '{
    MODE_ASM, MODE_C, MODE_COPY, MODE_C, MODE_ASM, MODE_SPARE,
    MODE_C, MODE_ASM, MODE_COPY, MODE_C, MODE_ASM
  };

  // Tracks the scan state of the block and holds the text bytes that are
  // still owed on the output channel.
  class stripped_text_board;
    logic [1:0] mode;
    logic [3:0] scan;
    bit halted;
    scs_res_t text_due[$];
    int unsigned n_checked;
    int unsigned n_mismatch;

    function new();
      mode = MODE_COPY;
      scan = '0;
      halted = 1'b0;
      n_checked = 0;
      n_mismatch = 0;
    endfunction

    function void set_mode(logic [1:0] m);
      mode = m;
      scan = '0;
    endfunction

    function int unsigned pending();
      return text_due.size();
    endfunction

    function int unsigned token_class(logic [7:0] b, bit asm_set);
      if (asm_set) begin
        foreach (ASM_TOKENS[i]) if (ASM_TOKENS[i] == b) return i;
        return $size(ASM_TOKENS);
      end
      foreach (CSRC_TOKENS[i]) if (CSRC_TOKENS[i] == b) return i;
      return $size(CSRC_TOKENS);
    endfunction

    // Action and next state for one byte from the current state. Plain copy
    // leaves the scan state alone; a row past the table end reads as row 0.
    function act_e scan_action(logic [7:0] b, output logic [3:0] nxt);
      logic [3:0] row;
      int unsigned col;
      row = scan;
      nxt = scan;
      if (mode == MODE_ASM) begin
        if (row >= ASM_ROWS) row = '0;
        col = token_class(b, 1'b1);
        nxt = ASM_GOTO[row][col];
        return ASM_DO[row][col];
      end
      if (mode == MODE_C) begin
        if (row >= CSRC_ROWS) row = '0;
        col = token_class(b, 1'b0);
        nxt = CSRC_GOTO[row][col];
        return CSRC_DO[row][col];
      end
      return ACT_COPY;
    endfunction

    function bit would_halt(logic [7:0] b);
      logic [3:0] nxt;
      if (halted) return 1'b0;
      return scan_action(b, nxt) == ACT_ERROR;
    endfunction

    function void owe(logic [7:0] d, logic l, logic e);
      scs_res_t r;
      r.data = d;
      r.last = l;
      r.err = e;
      text_due.push_back(r);
    endfunction

    // Called for every accepted source byte.
    function void strip_byte(logic [7:0] b);
      act_e a;
      logic [3:0] nxt;
      if (halted) return;
      a = scan_action(b, nxt);
      scan = nxt;
      case (a)
        ACT_ERROR: begin
          halted = 1'b1;
          owe(8'h00, 1'b1, 1'b1);
        end
        ACT_DROP: ;
        ACT_COPY: owe(b, 1'b1, 1'b0);
        ACT_NL: owe(CH_NL, 1'b1, 1'b0);
        ACT_TABCOPY: begin
          owe(CH_TAB, 1'b0, 1'b0);
          owe(b, 1'b1, 1'b0);
        end
        ACT_SLASH: owe(CH_SLASH, 1'b1, 1'b0);
        ACT_SLASHCOPY: begin
          owe(CH_SLASH, 1'b0, 1'b0);
          owe(b, 1'b1, 1'b0);
        end
        ACT_NLCOPY: begin
          owe(CH_NL, 1'b0, 1'b0);
          owe(b, 1'b1, 1'b0);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      n_mismatch++;
      if (n_mismatch <= 100) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_out_byte(logic [7:0] d, logic l, logic e);
      scs_res_t due;
      if (text_due.size() == 0) begin
        report($sformatf("unexpected result byte %02h last %b err %b", d, l, e));
        return;
      end
      due = text_due.pop_front();
      n_checked++;
      if (d !== due.data) report($sformatf("out_byte %02h, wanted %02h", d, due.data));
      if (l !== due.last) report($sformatf("last_of_run %b, wanted %b", l, due.last));
      if (e !== due.err) report($sformatf("error_flag %b, wanted %b", e, due.err));
    endtask
  endclass

  // Clock and a single reset at the start of the run.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  // Everything the bench drives starts at a known value.
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_of_run_o;
  logic        error_flag_o;

  // Idle rates in percent for the sending and the receiving side.
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned n_sent = 0;

  stripped_text_board board;

  source_comment_stripper_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .error_flag_o  (error_flag_o)
  );

  // Output side. Signals are read at the rising edge before the block's own
  // updates land, so a result transaction is taken exactly when valid is high
  // and our stall was low. The stall for the next cycle is drawn right here.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_out_byte(out_byte_o, last_of_run_o, error_flag_o);
    out_stall_i <= rst_ni && ($urandom_range(99) < receiver_stall_pct);
  end

  // Sends one source byte: optional idle cycles first, then valid is held
  // until the block takes the transaction. Valid is not dropped between
  // back-to-back bytes, so it gets one assignment per edge at most.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.strip_byte(b);
    n_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // Waits until every owed result has come out, then keeps waiting so that a
  // byte that produces nothing has left the pipeline too.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the language mode with a setup and an access cycle, then reads it
  // back the same way.
  task automatic write_mode(input logic [1:0] m);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MODE_ADDR;
    pwdata <= {30'd0, m};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.set_mode(m);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[1:0] !== m)
      board.report($sformatf("language_mode reads %b, wrote %b", prdata[1:0], m));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Text-like bytes: mostly letters, digits and the active token set, with the other
  // language's tokens and arbitrary bytes mixed in as noise; copy modes get arbitrary bytes only.
  function automatic logic [7:0] pick_text_byte(input logic [1:0] m);
    int unsigned r;
    bit asm_set;
    if (m != MODE_ASM && m != MODE_C) return 8'($urandom_range(255));
    asm_set = (m == MODE_ASM);
    r = $urandom_range(99);
    if (r < 6) return 8'($urandom_range(255));
    if (r < 40) return 8'($urandom_range(8'h7A, 8'h61));
    if (r < 50) return 8'($urandom_range(8'h39, 8'h30));
    if (r < 88 && asm_set) return ASM_TOKENS[$urandom_range(10)];
    if (r < 88) return CSRC_TOKENS[$urandom_range(7)];
    if (asm_set) return CSRC_TOKENS[$urandom_range(7)];
    return ASM_TOKENS[$urandom_range(10)];
  endfunction

  initial begin : stimulus
    logic [7:0] b;
    board = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Reset leaves the block in plain copy, so the byte
    // extremes go through untouched first.
    sender_idle_pct = 6;
    receiver_stall_pct = 60;
    push_byte(8'h00);
    push_byte(8'hFF);
    settle();

    // An assembler line with a label, an opcode, operands and a trailing
    // comment: drops, tab insertion, copies and a newline action.
    write_mode(MODE_ASM);
    push_text("b: m a,b ;x\n");
    settle();

    // C text: a lone slash before a letter, a line comment opener followed by
    // text, a string with an escaped quote and a block comment.
    write_mode(MODE_C);
    push_text("a/q//x\"\\\"\"/**/");
    settle();

    // Random part. The halting error is kept for the very end, because only
    // a reset clears it and the run resets once; any byte that would trigger
    // it here is drawn again.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        sender_idle_pct = 6;
        receiver_stall_pct = 60;
      end else if (p < 8) begin
        sender_idle_pct = 60;
        receiver_stall_pct = 6;
      end else begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      write_mode(PHASE_MODES[p]);
      for (int k = 0; k < PHASE_BYTES; k++) begin
        do b = pick_text_byte(PHASE_MODES[p]); while (board.would_halt(b));
        push_byte(b);
      end
      settle();
    end

    // Error action: a newline inside a C string. The block reports it once
    // and then ignores input; a mode write must not wake it up.
    sender_idle_pct = 6;
    receiver_stall_pct = 60;
    write_mode(MODE_C);
    push_text("\"\nzz");
    settle();
    write_mode(MODE_ASM);
    push_byte(8'h6B);
    in_valid_i <= 1'b0;

    // Drain with a bound, then keep the clock running so the block can show
    // anything it should not produce.
    receiver_stall_pct = 0;
    for (int k = 0; k < 4000 && board.pending() != 0; k++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.pending() != 0)
      board.report($sformatf("%0d result bytes never arrived", board.pending()));

    $display("Summary: %0d source bytes over copy, assembler and C phases, %0d results checked.",
             n_sent, board.n_checked);
    $display("Summary: error halt exercised last; %0d mismatches.", board.n_mismatch);
    if (board.n_mismatch == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin : watchdog
    #(4_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/scs_pkg.sv
rtl/core/scs_scan.sv
rtl/core/source_comment_stripper_top.sv
bench/source_comment_stripper_top_tb.sv
